>>> hw/rtl/spq_pkg.sv
// shared types and constants for the sorted priority queue
`default_nettype none

package spq_pkg;

    localparam int DEPTH = 16;
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        REQ_INSERT    = 2'd0,
        REQ_POP_FRONT = 2'd1,
        REQ_POP_BACK  = 2'd2
    } t_req;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic signed [31:0] value;
        logic signed [31:0] prio;
    } t_entry;

    // broadcast to every cell
    typedef struct packed {
        logic   insert;
        logic   pop_front;
        t_entry item;
    } t_cell_ctrl;

endpackage

`default_nettype wire

>>> hw/rtl/sorted_priority_queue.sv
// sorted priority queue built as a chain of shifting cells
//
//  channel | direction | handshake               | payload
//  in      | input     | i_in_valid / o_in_ready | req_type, item_value, item_priority
//  out     | output    | o_out_valid/ i_out_ready| popped_value, popped_priority,
//          |           |                         | status, fill_level
//
// one request per cycle while no result is stalled: every cell compares and shifts in
// the cycle the request is accepted, and the output register takes the result at the same edge as the cells.
// the back pop reads the last held cell through a one-hot select over all cells.
// reset clears the count and the output valid; cell contents are not reset.
// a stalled result holds the output register and blocks new requests only
// while it waits.
`default_nettype none

module sorted_priority_queue (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output      logic               o_in_ready,
    input  wire logic        [1:0]  i_req_type,
    input  wire logic signed [31:0] i_item_value,
    input  wire logic signed [31:0] i_item_priority,
    output      logic               o_out_valid,
    input  wire logic               i_out_ready,
    output      logic signed [31:0] o_popped_value,
    output      logic signed [31:0] o_popped_priority,
    output      logic        [1:0]  o_status,
    output      logic        [4:0]  o_fill_level
);
    import spq_pkg::*;

    logic             r_out_valid;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    t_entry           r_res;
    t_entry           n_res;
    t_status          r_status;
    t_status          n_status;

    logic       accept;
    logic       full;
    logic       empty;
    t_cell_ctrl ctrl;
    t_entry     back_entry;

    t_entry     cell_entry [DEPTH];
    logic       cell_keep  [DEPTH];

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;
    assign full       = (r_count == CNT_W'(DEPTH));
    assign empty      = (r_count == '0);

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            t_entry left_entry;
            t_entry right_entry;
            logic   left_keep;

            if (g == 0) begin : g_head
                assign left_entry = ctrl.item;
                assign left_keep  = 1'b1;
            end else begin : g_body
                assign left_entry = cell_entry[g-1];
                assign left_keep  = cell_keep[g-1];
            end

            if (g == DEPTH - 1) begin : g_tail
                assign right_entry = ctrl.item;
            end else begin : g_mid
                assign right_entry = cell_entry[g+1];
            end

            spq_cell u_cell (
                .i_clk       (i_clk),
                .i_ctrl      (ctrl),
                .i_occupied  (CNT_W'(g) < r_count),
                .i_left      (left_entry),
                .i_left_keep (left_keep),
                .i_right     (right_entry),
                .o_entry     (cell_entry[g]),
                .o_keep      (cell_keep[g])
            );
        end
    endgenerate

    // last held entry, selected one-hot
    always_comb begin
        back_entry = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (CNT_W'(i + 1) == r_count) begin
                back_entry = back_entry | cell_entry[i];
            end
        end
    end

    always_comb begin
        ctrl.insert    = 1'b0;
        ctrl.pop_front = 1'b0;
        ctrl.item.value = i_item_value;
        ctrl.item.prio  = i_item_priority;
        n_count  = r_count;
        n_res    = '0;
        n_status = ST_OK;
        case (t_req'(i_req_type))
            REQ_INSERT: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    ctrl.insert = accept;
                    n_count     = r_count + 1'b1;
                end
            end
            REQ_POP_FRONT: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    ctrl.pop_front = accept;
                    n_res          = cell_entry[0];
                    n_count        = r_count - 1'b1;
                end
            end
            REQ_POP_BACK: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_res   = back_entry;
                    n_count = r_count - 1'b1;
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            if (accept) begin
                r_out_valid <= 1'b1;
                r_count     <= n_count;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res    <= n_res;
            r_status <= n_status;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_popped_value    = r_res.value;
    assign o_popped_priority = r_res.prio;
    assign o_status          = r_status;
    assign o_fill_level      = 5'(r_count);

endmodule

`default_nettype wire

>>> hw/rtl/spq_cell.sv
// one slot of the sorted cell chain
`default_nettype none

module spq_cell (
    input  wire logic               i_clk,
    input  wire spq_pkg::t_cell_ctrl i_ctrl,
    input  wire logic               i_occupied,
    input  wire spq_pkg::t_entry    i_left,
    input  wire logic               i_left_keep,
    input  wire spq_pkg::t_entry    i_right,
    output      spq_pkg::t_entry    o_entry,
    output      logic               o_keep
);
    import spq_pkg::*;

    t_entry r_entry;
    t_entry n_entry;

    // a held entry stays in place when its priority is not below the new one
    assign o_keep  = i_occupied && !(r_entry.prio < i_ctrl.item.prio);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctrl.insert) begin
            if (o_keep) begin
                n_entry = r_entry;
            end else if (i_left_keep) begin
                n_entry = i_ctrl.item;
            end else begin
                n_entry = i_left;
            end
        end else if (i_ctrl.pop_front) begin
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

`default_nettype wire

>>> hw/rtl/spq_chk.sv
// port-level checks for the sorted priority queue
`default_nettype none

module spq_chk (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               o_in_ready,
    input wire logic               o_out_valid,
    input wire logic               i_out_ready,
    input wire logic signed [31:0] o_popped_value,
    input wire logic signed [31:0] o_popped_priority,
    input wire logic        [1:0]  o_status,
    input wire logic        [4:0]  o_fill_level
);
    import spq_pkg::*;

    // a waiting result holds still
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_popped_value) && $stable(o_popped_priority)
            && $stable(o_status) && $stable(o_fill_level))
        else $error("result changed while stalled");

    // an empty pop reports nothing held and no item
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_EMPTY) |->
            (o_fill_level == '0) && (o_popped_value == '0) && (o_popped_priority == '0))
        else $error("empty pop with data or nonzero fill");

    // a dropped insert reports the queue as full
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_FULL) |->
            (o_fill_level == 5'(DEPTH)) && (o_popped_value == '0))
        else $error("full drop with wrong fill or data");

    // every accepted request gives a result in the next cycle
    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> o_out_valid)
        else $error("accepted request gave no result");

endmodule

bind sorted_priority_queue spq_chk u_spq_chk (.*);

`default_nettype wire
